// ===== rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the rangefinder sample packet parser.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam logic [7:0]  SYNC_FIRST_RESET  = 8'd170;
   localparam logic [7:0]  SYNC_SECOND_RESET = 8'd85;
   localparam int          HEADER_BYTES      = 10;
   localparam logic [16:0] FULL_TURN_Q6      = 17'd23040;
   localparam int          DIV_WIDTH         = 23;
   localparam int          DIV_CNT_WIDTH     = $clog2(DIV_WIDTH);

   localparam logic CSR_SYNC_FIRST  = 1'b0;
   localparam logic CSR_SYNC_SECOND = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [7:0]           divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
      logic                 rem_nonzero;
   } div_rsp_type;

endpackage

// ===== rtl/lsp_div.sv =====
// ----------------------------------------------------------------------------
// lsp_div
// Restoring divider, one quotient bit per cycle, for angle interpolation.
// ----------------------------------------------------------------------------
module lsp_div
   import lsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [7:0]               rem_ff, rem_in;
   logic [7:0]               den_ff, den_in;
   logic [DIV_WIDTH-1:0]     quo_ff, quo_in;
   logic [8:0]               rem_shift;
   logic [9:0]               trial;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      rem_shift = {rem_ff, quo_ff[DIV_WIDTH-1]};
      trial     = {1'b0, rem_shift} - {2'b00, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_WIDTH'(DIV_WIDTH - 1);
         rem_in  = 8'd0;
         den_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (!trial[9]) begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[7:0];
            quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done        = done_ff;
   assign div_rsp.quotient    = quo_ff;
   assign div_rsp.rem_nonzero = (rem_ff != 8'd0);

endmodule

// ===== rtl/lidar_scan_packet_parser.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_packet_parser
// Byte-serial sample packet decoder: sync hunt, header capture, and per
// sample distance plus linearly interpolated angle.
//
//   channel  direction  handshake            words
//   req_     in         req_valid/req_ready  data_byte
//   rsp_     out        rsp_valid/rsp_ready  distance, angle, index, last flag
//   csr_     in/out     APB, pready high     sync_first / sync_second bytes
//
// Header and low sample bytes keep the parser idle and ready for the next
// byte. A byte that completes a sample goes through product, divider load,
// 23 steps of the single divider, angle fix-up and output load; a packet with
// a count of one skips the divider. The output register frees the parser to
// take the next byte while a word waits on rsp_ready; the next sample holds in
// the output load until that word is taken. Reset is synchronous; it clears
// the position and restores the sync bytes.
// ----------------------------------------------------------------------------
module lidar_scan_packet_parser
   import lsp_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [13:0] rsp_distance_mm,
   output logic [15:0] rsp_angle_q6,
   output logic [7:0]  rsp_sample_index,
   output logic        rsp_last_sample,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [9:0] MaxBytes = 10'(MAX_PACKET_BYTES);
   localparam logic [9:0] HdrBytes = 10'(HEADER_BYTES);

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_OUT} state_type;

   state_type        state_ff, state_in;
   logic [7:0]       sync0_ff, sync1_ff;
   logic [9:0]       pos_ff, pos_in;
   logic [7:0]       hdr0_ff, hdr0_in;
   logic [7:0]       count_ff, count_in;
   logic [3:0][7:0]  ang_ff, ang_in;
   logic [14:0]      start_ff, start_in;
   logic [15:0]      span_ff, span_in;
   logic [7:0]       low_ff, low_in;
   logic [13:0]      dist_ff, dist_in;
   logic [7:0]       idx_ff, idx_in;
   logic             last_ff, last_in;
   logic [23:0]      prod_ff, prod_in;
   logic [15:0]      angle_ff, angle_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [13:0]      rsp_dist_ff, rsp_dist_in;
   logic [15:0]      rsp_angle_ff, rsp_angle_in;
   logic [7:0]       rsp_idx_ff, rsp_idx_in;
   logic             rsp_last_ff, rsp_last_in;

   logic        accept;
   logic        csr_write;
   logic [9:0]  total;
   logic [9:0]  rel;
   logic [10:0] pos_next;
   logic [7:0]  idx_now;
   logic [14:0] sa, ea;
   logic [16:0] span_wide;
   logic [23:0] prod_mag;
   logic [22:0] q_mag;
   div_req_type div_req;
   div_rsp_type div_rsp;

   lsp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         CSR_SYNC_FIRST:  csr_prdata = {24'd0, sync0_ff};
         CSR_SYNC_SECOND: csr_prdata = {24'd0, sync1_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync0_ff <= SYNC_FIRST_RESET;
         sync1_ff <= SYNC_SECOND_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_SYNC_FIRST) begin
            sync0_ff <= csr_pwdata[7:0];
         end else begin
            sync1_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign total     = HdrBytes + {1'b0, count_ff, 1'b0};
   assign rel       = pos_ff - HdrBytes;
   assign pos_next  = {1'b0, pos_ff} + 11'd1;
   assign idx_now   = rel[8:1];
   assign sa        = {ang_ff[1], ang_ff[0][7:1]};
   assign ea        = {ang_ff[3], ang_ff[2][7:1]};
   assign span_wide = ({2'b00, ea} - {2'b00, sa}) + ((ea < sa) ? FULL_TURN_Q6 : 17'd0);
   assign prod_mag  = prod_ff[23] ? (24'd0 - prod_ff) : prod_ff;
   assign q_mag     = div_rsp.quotient + {22'd0, prod_ff[23] & div_rsp.rem_nonzero};

   assign div_req.start    = (state_ff == ST_LOAD);
   assign div_req.dividend = prod_mag[22:0];
   assign div_req.divisor  = count_ff - 8'd1;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      hdr0_in      = hdr0_ff;
      count_in     = count_ff;
      ang_in       = ang_ff;
      start_in     = start_ff;
      span_in      = span_ff;
      low_in       = low_ff;
      dist_in      = dist_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      angle_in     = angle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pos_ff < HdrBytes) begin
                  pos_in = pos_next[9:0];
                  if (pos_ff == 10'd0) begin
                     hdr0_in = req_data_byte;
                  end
                  if (pos_ff == 10'd1 &&
                      (hdr0_ff != sync0_ff || req_data_byte != sync1_ff)) begin
                     hdr0_in = req_data_byte;
                     pos_in  = 10'd1;
                  end
                  if (pos_ff == 10'd3) begin
                     count_in = req_data_byte;
                  end
                  if (pos_ff >= 10'd4 && pos_ff <= 10'd7) begin
                     ang_in[pos_ff[1:0]] = req_data_byte;
                  end
                  if (pos_ff == HdrBytes - 10'd1) begin
                     start_in = sa;
                     span_in  = span_wide[15:0];
                     if (count_ff == 8'd0) begin
                        pos_in = 10'd0;
                     end
                  end
               end else if (total > MaxBytes) begin
                  // swallow oversize packet
                  pos_in = (pos_next >= {1'b0, MaxBytes}) ? 10'd0 : pos_next[9:0];
               end else if (!rel[0]) begin
                  low_in = req_data_byte;
                  pos_in = pos_next[9:0];
               end else begin
                  dist_in = {req_data_byte, low_ff[7:2]};
                  idx_in  = idx_now;
                  last_in = ({1'b0, idx_now} + 9'd1) == {1'b0, count_ff};
                  prod_in = 24'($signed(span_ff) * $signed({1'b0, idx_now}));
                  pos_in  = (pos_next >= {1'b0, total}) ? 10'd0 : pos_next[9:0];
                  if (count_ff == 8'd1) begin
                     angle_in = {1'b0, start_ff};
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               angle_in = prod_ff[23] ? ({1'b0, start_ff} - q_mag[15:0])
                                      : ({1'b0, start_ff} + q_mag[15:0]);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = dist_ff;
               rsp_angle_in = angle_ff;
               rsp_idx_in   = idx_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 10'd0;
         count_ff     <= 8'd0;
         start_ff     <= 15'd0;
         span_ff      <= 16'd0;
         low_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         span_ff      <= span_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdr0_ff      <= hdr0_in;
      ang_ff       <= ang_in;
      dist_ff      <= dist_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      prod_ff      <= prod_in;
      angle_ff     <= angle_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance_mm  = rsp_dist_ff;
   assign rsp_angle_q6     = rsp_angle_ff;
   assign rsp_sample_index = rsp_idx_ff;
   assign rsp_last_sample  = rsp_last_ff;

endmodule
